// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define FQD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Implication shorthand.
`define FQD_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ===== rtl/fqd_pkg.sv =====
// ---------------------------------------------------------------------------
// fqd_pkg
// Shared sizes, codes and types of the tag queue with delete.
// ---------------------------------------------------------------------------
package fqd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_WIDTH   = 32;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQ = 2'd0,
        ACT_DEQ = 2'd1,
        ACT_DEL = 2'd2
    } act_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic                 shift_all;
        logic                 del_go;
        logic                 load;
        logic [TAG_WIDTH-1:0] tag;
    } cell_ctl_t;

endpackage

// ===== rtl/fqd_cell.sv =====
// ---------------------------------------------------------------------------
// fqd_cell
// One queue slot: holds a tag, compares it, loads it at the tail, shifts from its right neighbor.
// ---------------------------------------------------------------------------
module fqd_cell (
    input  logic                          clk,
    input  fqd_pkg::cell_ctl_t            ctl,
    input  logic                          live,
    input  logic                          tail,
    input  logic                          hit_in,
    input  logic [fqd_pkg::TAG_WIDTH-1:0] right_data,
    output logic [fqd_pkg::TAG_WIDTH-1:0] data,
    output logic                          hit_out
);
    import fqd_pkg::*;

    logic [TAG_WIDTH-1:0] data_reg;
    logic [TAG_WIDTH-1:0] data_next;
    logic                 match;

    assign match   = live && (data_reg == ctl.tag);
    assign hit_out = hit_in || match;
    assign data    = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift_all || (ctl.del_go && hit_out))
        begin
            data_next = right_data;
        end
        else if (ctl.load && tail)
        begin
            data_next = ctl.tag;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== rtl/fifo_queue_with_delete.sv =====
// ---------------------------------------------------------------------------
// fifo_queue_with_delete
// Bounded order-keeping queue of nonzero tags with delete of the first match.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy is high during
// reset and in the first cycle after it. The command is registered, then
// executed in the next cycle across a row of slot cells that compare every
// entry in parallel and shift toward the head; done is high for one cycle,
// registered with status, tag_out and occupancy as the command executes.
// One item is taken every cycle, so the rate is one item per cycle. The
// receiver cannot stall: a result not taken during its done cycle is gone.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_queue_with_delete (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fqd_pkg::ACTION_W-1:0]  action,
    input  logic [fqd_pkg::TAG_WIDTH-1:0] tag_in,
    output logic                          done,
    output logic [fqd_pkg::STATUS_W-1:0]  status,
    output logic [fqd_pkg::TAG_WIDTH-1:0] tag_out,
    output logic [fqd_pkg::CNT_W-1:0]     occupancy
);
    import fqd_pkg::*;

    logic                 ready_reg;
    logic                 cmd_vld_reg;
    logic [ACTION_W-1:0]  cmd_act_reg;
    logic [TAG_WIDTH-1:0] cmd_tag_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 done_reg;
    status_t              status_reg;
    status_t              status_next;
    logic [TAG_WIDTH-1:0] tag_out_reg;
    logic [TAG_WIDTH-1:0] tag_out_next;

    cell_ctl_t            ctl;
    logic [TAG_WIDTH-1:0] cell_data [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] hit;
    logic                 found;
    logic                 is_null;
    logic                 empty;
    logic                 full;

    assign busy = !ready_reg;

    assign hit[0]  = 1'b0;
    assign found   = hit[QUEUE_DEPTH];
    assign is_null = (cmd_tag_reg == '0);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [TAG_WIDTH-1:0] right;

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right = cell_data[i];
        end
        else
        begin : g_mid
            assign right = cell_data[i+1];
        end

        fqd_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .live       (CNT_W'(i) < count_reg),
            .tail       (CNT_W'(i) == count_reg),
            .hit_in     (hit[i]),
            .right_data (right),
            .data       (cell_data[i]),
            .hit_out    (hit[i+1])
        );
    end

    always_comb
    begin
        ctl          = '0;
        ctl.tag      = cmd_tag_reg;
        status_next  = ST_OK;
        tag_out_next = '0;
        count_next   = count_reg;
        if (cmd_vld_reg)
        begin
            unique case (act_t'(cmd_act_reg))
                ACT_ENQ:
                begin
                    if (is_null)
                        status_next = ST_NULL;
                    else if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctl.load   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_DEQ:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        ctl.shift_all = 1'b1;
                        tag_out_next  = cell_data[0];
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
                ACT_DEL:
                begin
                    if (is_null)
                        status_next = ST_NULL;
                    else if (empty)
                        status_next = ST_EMPTY;
                    else if (!found)
                        status_next = ST_NOTFOUND;
                    else
                    begin
                        ctl.del_go = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg   <= 1'b0;
            cmd_vld_reg <= 1'b0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            ready_reg   <= 1'b1;
            cmd_vld_reg <= start && ready_reg;
            count_reg   <= count_next;
            done_reg    <= cmd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && ready_reg)
        begin
            cmd_act_reg <= action;
            cmd_tag_reg <= tag_in;
        end
        status_reg  <= status_next;
        tag_out_reg <= tag_out_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign tag_out   = tag_out_reg;
    assign occupancy = count_reg;

    `FQD_ASSERT(a_count_max, count_reg <= CNT_W'(QUEUE_DEPTH), "count above depth")
    `FQD_ASSERT_IMP(a_occ_step, done, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_W'(1)) || (count_reg + CNT_W'(1) == $past(count_reg)), "occupancy jumped")
    `FQD_ASSERT_IMP(a_deq_shrinks, done && (tag_out != '0), count_reg + CNT_W'(1) == $past(count_reg), "dequeue without shrink")
    `FQD_ASSERT_IMP(a_no_hit_empty, cmd_vld_reg && (count_reg == '0), !found, "match in empty queue")

endmodule
